// ===== hdl/ssgpm_pkg.sv =====
`timescale 1ns / 1ps

package ssgpm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 21;

    localparam int GAIN_W     = 23;
    localparam int RAMP_EXTRA = 8;
    localparam int RAMP_W     = GAIN_W + RAMP_EXTRA;
    localparam int STEP_W     = RAMP_W + 1;
    localparam int LEN_W      = 16;
    localparam int COEF_W     = 24;
    localparam int LEVEL_W    = 26;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TRIM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO       = 3'd5;

    localparam logic [GAIN_W-1:0] INPUT_GAIN_RST  = 23'd2097152;
    localparam logic [GAIN_W-1:0] OUTPUT_TRIM_RST = 23'd2097152;
    localparam logic [LEN_W-1:0]  RAMP_LENGTH_RST = 16'd960;
    localparam logic [COEF_W-1:0] RELEASE_RST     = 24'd16775349;

    // ramp selector
    localparam logic SEL_IN  = 1'b0;
    localparam logic SEL_OUT = 1'b1;

    typedef struct packed {
        logic capture;
        logic mul_gain;
        logic round;
        logic mul_trim;
        logic out_load;
        logic div_start;
        logic div_sel;
        logic ramp_load;
        logic ramp_sel;
    } t_cmd;

    typedef struct packed {
        logic in_req;
        logic out_req;
        logic div_done;
    } t_stat;

endpackage

// ===== hdl/smoothed_stereo_gain_peak_meter_unit.sv =====
`timescale 1ns / 1ps

// Channel     Dir  Handshake            Payload
// s_axis      in   tvalid/tready        tdata: left_sample, right_sample
// m_axis      out  tvalid/tready        tdata: left_out, right_out, left_level, right_level
// cfg         in   we (no wait)         idx, data (24 bit)
//
// A sample pair passes these steps from transfer in to result ready: accept, input gain
// multiply, rounding plus meter decay multiply, output trim multiply, output load.
// The next pair is taken once the result sits in the output register.
// A gain or trim write that changes its target requests a step division;
// s_axis is held off until all pending divisions are done.
// Reset is synchronous, active low; no clearing pass. The output register holds
// while m_axis stalls, and s_axis then accepts one pair ahead of it.

module smoothed_stereo_gain_peak_meter_unit #(
    parameter int SAMPLE_BITS = ssgpm_pkg::SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // left_sample, right_sample, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // left_out, right_out, left_level, right_level, zero pad
    output logic [((2*SAMPLE_BITS+2*ssgpm_pkg::LEVEL_W+7)/8)*8-1:0] o_m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [ssgpm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssgpm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int VW    = ssgpm_pkg::LEVEL_W;
    localparam int OUT_W = ((2*SB+2*VW+7)/8)*8;

    ssgpm_pkg::t_cmd  w_cmd;
    ssgpm_pkg::t_stat w_stat;

    logic [SB-1:0] w_left_out, w_right_out;
    logic [VW-1:0] w_left_level, w_right_level;

    ssgpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ssgpm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_left        (i_s_axis_tdata[SB-1:0]),
        .i_right       (i_s_axis_tdata[2*SB-1:SB]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_left_out    (w_left_out),
        .o_right_out   (w_right_out),
        .o_left_level  (w_left_level),
        .o_right_level (w_right_level)
    );

    assign o_m_axis_tdata = OUT_W'({w_right_level, w_left_level, w_right_out, w_left_out});

endmodule

// ===== hdl/ssgpm_div.sv =====
`timescale 1ns / 1ps

module ssgpm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_neg,
    input  logic [ssgpm_pkg::RAMP_W-1:0]        i_mag,
    input  logic [ssgpm_pkg::LEN_W-1:0]         i_den,
    output logic                                o_done,
    output logic [ssgpm_pkg::STEP_W-1:0]        o_quo
);

    localparam int RW    = ssgpm_pkg::RAMP_W;
    localparam int LW    = ssgpm_pkg::LEN_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [RW-1:0]    r_acc, n_acc;
    logic [LW-1:0]    r_rem, n_rem;
    logic [LW-1:0]    r_den, n_den;
    logic             r_neg, n_neg;

    logic [LW:0]      w_trial;
    logic [LW:0]      w_diff;
    logic             w_ge;

    // restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_acc[RW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(RW);
            n_acc  = i_mag;
            n_rem  = '0;
            n_den  = i_den;
            n_neg  = i_neg;
        end else if (r_busy) begin
            n_acc = {r_acc[RW-2:0], w_ge};
            n_rem = w_ge ? w_diff[LW-1:0] : w_trial[LW-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (ssgpm_pkg::STEP_W'(0) - {1'b0, r_acc}) : {1'b0, r_acc};

endmodule

// ===== hdl/ssgpm_dp.sv =====
`timescale 1ns / 1ps

module ssgpm_dp #(
    parameter int SAMPLE_BITS = ssgpm_pkg::SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ssgpm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ssgpm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]                 i_left,
    input  logic [SAMPLE_BITS-1:0]                 i_right,
    input  ssgpm_pkg::t_cmd                        i_cmd,
    output ssgpm_pkg::t_stat                       o_stat,
    output logic [SAMPLE_BITS-1:0]                 o_left_out,
    output logic [SAMPLE_BITS-1:0]                 o_right_out,
    output logic [ssgpm_pkg::LEVEL_W-1:0]          o_left_level,
    output logic [ssgpm_pkg::LEVEL_W-1:0]          o_right_level
);

    localparam int SB    = SAMPLE_BITS;
    localparam int GW    = ssgpm_pkg::GAIN_W;
    localparam int GFB   = ssgpm_pkg::GAIN_FRAC_BITS;
    localparam int RW    = ssgpm_pkg::RAMP_W;
    localparam int EXT   = ssgpm_pkg::RAMP_EXTRA;
    localparam int SW    = ssgpm_pkg::STEP_W;
    localparam int LW    = ssgpm_pkg::LEN_W;
    localparam int CW    = ssgpm_pkg::COEF_W;
    localparam int VW    = ssgpm_pkg::LEVEL_W;
    // magnitude of a gained sample after rounding
    localparam int LM_W  = SB + GW - 1 - GFB;
    localparam int MA_W  = (LM_W > VW) ? LM_W : VW;
    localparam int P_W   = MA_W + CW;
    localparam logic [P_W-1:0] HALF   = P_W'(1) << (GFB - 1);
    localparam logic [P_W-1:0] POS_MAX = (P_W'(1) << (SB - 1)) - P_W'(1);
    localparam logic [P_W-1:0] NEG_MAG = P_W'(1) << (SB - 1);
    localparam logic [SB-1:0]  SAT_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0]  SAT_NEG = {1'b1, {(SB-1){1'b0}}};

    // configuration
    logic [GW-1:0] r_in_gain, r_out_trim;
    logic [LW-1:0] r_ramp_len;
    logic [CW-1:0] r_rel;
    logic          r_bypass, r_stereo;
    logic [LW-1:0] r_in_len, r_out_len;

    // ramps
    logic [RW-1:0] r_in_now, n_in_now, r_out_now, n_out_now;
    logic [SW-1:0] r_in_step, r_out_step;
    logic [LW-1:0] r_in_left, n_in_left, r_out_left, n_out_left;

    // meters
    logic [VW-1:0] r_env_l, r_env_r;

    // sample path
    logic [SB-1:0]   r_raw_l, r_raw_r;
    logic            r_xs_l, r_xs_r;
    logic [SB-1:0]   r_xm_l, r_xm_r;
    logic [P_W-1:0]  r_prod_l, r_prod_r;
    logic            r_ls_l, r_ls_r;
    logic [LM_W-1:0] r_lm_l, r_lm_r;
    logic [SB-1:0]   r_o_l, r_o_r;
    logic [VW-1:0]   r_o_lvl_l, r_o_lvl_r;

    logic [LW-1:0]   w_len_eff;
    logic            w_in_chg, w_out_chg;

    always_comb begin
        w_len_eff = (r_ramp_len == '0) ? LW'(1) : r_ramp_len;
        w_in_chg  = i_cfg_we && (i_cfg_idx == ssgpm_pkg::REG_INPUT_GAIN)
                    && (i_cfg_data[GW-1:0] != r_in_gain);
        w_out_chg = i_cfg_we && (i_cfg_idx == ssgpm_pkg::REG_OUTPUT_TRIM)
                    && (i_cfg_data[GW-1:0] != r_out_trim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_gain  <= ssgpm_pkg::INPUT_GAIN_RST;
            r_out_trim <= ssgpm_pkg::OUTPUT_TRIM_RST;
            r_ramp_len <= ssgpm_pkg::RAMP_LENGTH_RST;
            r_rel      <= ssgpm_pkg::RELEASE_RST;
            r_bypass   <= 1'b0;
            r_stereo   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssgpm_pkg::REG_INPUT_GAIN:  r_in_gain  <= i_cfg_data[GW-1:0];
                ssgpm_pkg::REG_OUTPUT_TRIM: r_out_trim <= i_cfg_data[GW-1:0];
                ssgpm_pkg::REG_RAMP_LENGTH: r_ramp_len <= i_cfg_data[LW-1:0];
                ssgpm_pkg::REG_RELEASE:     r_rel      <= i_cfg_data[CW-1:0];
                ssgpm_pkg::REG_BYPASS:      r_bypass   <= i_cfg_data[0];
                ssgpm_pkg::REG_STEREO:      r_stereo   <= i_cfg_data[0];
                default: ;
            endcase
        end
        // ramp length is taken when the ramp is requested
        if (w_in_chg) begin
            r_in_len <= w_len_eff;
        end
        if (w_out_chg) begin
            r_out_len <= w_len_eff;
        end
    end

    assign o_stat.in_req  = w_in_chg;
    assign o_stat.out_req = w_out_chg;

    // ramp step divider
    logic [RW-1:0] w_tgt, w_now, w_mag;
    logic [LW-1:0] w_den;
    logic          w_neg, w_div_done;
    logic [SW-1:0] w_quo;

    always_comb begin
        if (i_cmd.div_sel == ssgpm_pkg::SEL_OUT) begin
            w_tgt = {r_out_trim, {EXT{1'b0}}};
            w_now = r_out_now;
            w_den = r_out_len;
        end else begin
            w_tgt = {r_in_gain, {EXT{1'b0}}};
            w_now = r_in_now;
            w_den = r_in_len;
        end
        w_neg = (w_now > w_tgt);
        w_mag = w_neg ? (w_now - w_tgt) : (w_tgt - w_now);
    end

    ssgpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_neg   (w_neg),
        .i_mag   (w_mag),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_stat.div_done = w_div_done;

    // ramp advance, once per accepted sample when not in bypass
    logic [SW-1:0] w_in_sum, w_out_sum;

    always_comb begin
        w_in_sum   = {1'b0, r_in_now} + r_in_step;
        w_out_sum  = {1'b0, r_out_now} + r_out_step;
        n_in_now   = r_in_now;
        n_in_left  = r_in_left;
        n_out_now  = r_out_now;
        n_out_left = r_out_left;
        if (i_cmd.capture && !r_bypass) begin
            if (r_in_left != '0) begin
                n_in_left = r_in_left - LW'(1);
                n_in_now  = (r_in_left == LW'(1)) ? {r_in_gain, {EXT{1'b0}}}
                                                  : w_in_sum[RW-1:0];
            end
            if (r_out_left != '0) begin
                n_out_left = r_out_left - LW'(1);
                n_out_now  = (r_out_left == LW'(1)) ? {r_out_trim, {EXT{1'b0}}}
                                                    : w_out_sum[RW-1:0];
            end
        end
        if (i_cmd.ramp_load) begin
            if (i_cmd.ramp_sel == ssgpm_pkg::SEL_OUT) begin
                n_out_left = r_out_len;
            end else begin
                n_in_left = r_in_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_now   <= {ssgpm_pkg::INPUT_GAIN_RST, {EXT{1'b0}}};
            r_out_now  <= {ssgpm_pkg::OUTPUT_TRIM_RST, {EXT{1'b0}}};
            r_in_step  <= '0;
            r_out_step <= '0;
            r_in_left  <= '0;
            r_out_left <= '0;
        end else begin
            r_in_now   <= n_in_now;
            r_out_now  <= n_out_now;
            r_in_left  <= n_in_left;
            r_out_left <= n_out_left;
            if (i_cmd.ramp_load && i_cmd.ramp_sel == ssgpm_pkg::SEL_IN) begin
                r_in_step <= w_quo;
            end
            if (i_cmd.ramp_load && i_cmd.ramp_sel == ssgpm_pkg::SEL_OUT) begin
                r_out_step <= w_quo;
            end
        end
    end

    // one multiplier per lane, operands chosen by phase
    logic [MA_W-1:0] w_a_l, w_a_r;
    logic [CW-1:0]   w_b;
    logic [P_W-1:0]  w_mul_l, w_mul_r;

    always_comb begin
        if (i_cmd.mul_gain) begin
            w_a_l = MA_W'(r_xm_l);
            w_a_r = MA_W'(r_xm_r);
            w_b   = CW'(r_in_now[RW-1:EXT]);
        end else if (i_cmd.mul_trim) begin
            w_a_l = MA_W'(r_lm_l);
            w_a_r = MA_W'(r_lm_r);
            w_b   = CW'(r_out_now[RW-1:EXT]);
        end else begin
            w_a_l = MA_W'(r_env_l);
            w_a_r = MA_W'(r_env_r);
            w_b   = r_rel;
        end
        w_mul_l = P_W'(w_a_l) * P_W'(w_b);
        w_mul_r = P_W'(w_a_r) * P_W'(w_b);
    end

    logic [P_W-1:0]  w_sum_l, w_sum_r, w_q_l, w_q_r;
    logic [MA_W-1:0] w_lmx_l, w_lmx_r;
    logic [VW-1:0]   w_pk_l, w_pk_r, w_dec_l, w_dec_r;
    logic [SB-1:0]   w_sat_l, w_sat_r;

    // round half away from zero on magnitudes
    always_comb begin
        w_sum_l = r_prod_l + HALF;
        w_sum_r = r_prod_r + HALF;
        w_q_l   = w_sum_l >> GFB;
        w_q_r   = w_sum_r >> GFB;
        w_lmx_l = MA_W'(r_lm_l);
        w_lmx_r = MA_W'(r_lm_r);
        w_pk_l  = (w_lmx_l > MA_W'(ssgpm_pkg::LEVEL_MAX)) ? ssgpm_pkg::LEVEL_MAX
                                                          : w_lmx_l[VW-1:0];
        w_pk_r  = (w_lmx_r > MA_W'(ssgpm_pkg::LEVEL_MAX)) ? ssgpm_pkg::LEVEL_MAX
                                                          : w_lmx_r[VW-1:0];
        w_dec_l = r_prod_l[VW+CW-1:CW];
        w_dec_r = r_prod_r[VW+CW-1:CW];
        if (!r_ls_l) begin
            w_sat_l = (w_q_l > POS_MAX) ? SAT_POS : w_q_l[SB-1:0];
        end else begin
            w_sat_l = (w_q_l > NEG_MAG) ? SAT_NEG : (SB'(0) - w_q_l[SB-1:0]);
        end
        if (!r_ls_r) begin
            w_sat_r = (w_q_r > POS_MAX) ? SAT_POS : w_q_r[SB-1:0];
        end else begin
            w_sat_r = (w_q_r > NEG_MAG) ? SAT_NEG : (SB'(0) - w_q_r[SB-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_l <= '0;
            r_env_r <= '0;
        end else if (i_cmd.mul_trim) begin
            if (r_bypass) begin
                r_env_l <= w_dec_l;
                r_env_r <= w_dec_r;
            end else begin
                r_env_l <= (w_pk_l > r_env_l) ? w_pk_l : w_dec_l;
                r_env_r <= (w_pk_r > r_env_r) ? w_pk_r : w_dec_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw_l <= i_left;
            r_raw_r <= i_right;
            r_xs_l  <= i_left[SB-1];
            r_xs_r  <= i_right[SB-1];
            r_xm_l  <= i_left[SB-1] ? (SB'(0) - i_left) : i_left;
            r_xm_r  <= i_right[SB-1] ? (SB'(0) - i_right) : i_right;
        end
        if (i_cmd.mul_gain || i_cmd.round || i_cmd.mul_trim) begin
            r_prod_l <= w_mul_l;
            r_prod_r <= w_mul_r;
        end
        if (i_cmd.round) begin
            r_lm_l <= w_q_l[LM_W-1:0];
            r_ls_l <= r_xs_l;
            // mono: right lane runs on the gained left sample
            r_lm_r <= r_stereo ? w_q_r[LM_W-1:0] : w_q_l[LM_W-1:0];
            r_ls_r <= r_stereo ? r_xs_r : r_xs_l;
        end
        if (i_cmd.out_load) begin
            r_o_l     <= r_bypass ? r_raw_l : w_sat_l;
            r_o_r     <= !r_stereo ? '0 : (r_bypass ? r_raw_r : w_sat_r);
            r_o_lvl_l <= r_env_l;
            r_o_lvl_r <= r_stereo ? r_env_r : r_env_l;
        end
    end

    assign o_left_out    = r_o_l;
    assign o_right_out   = r_o_r;
    assign o_left_level  = r_o_lvl_l;
    assign o_right_level = r_o_lvl_r;

endmodule

// ===== hdl/ssgpm_ctrl.sv =====
`timescale 1ns / 1ps

module ssgpm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ssgpm_pkg::t_stat   i_stat,
    output ssgpm_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_MUL_GAIN = 5'b00010,
        S_ROUND    = 5'b00100,
        S_MUL_TRIM = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_pend, n_pend;
    logic       r_div_busy, n_div_busy;
    logic       r_div_sel, n_div_sel;
    logic       w_in_ready;

    always_comb begin
        w_in_ready = (r_state == S_IDLE) && (r_pend == 2'b00) && !r_div_busy
                     && !i_stat.in_req && !i_stat.out_req;
        o_cmd           = '0;
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        n_pend          = r_pend;
        n_div_busy      = r_div_busy;
        n_div_sel       = r_div_sel;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && w_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL_GAIN;
                end
            end
            S_MUL_GAIN: begin
                o_cmd.mul_gain = 1'b1;
                n_state        = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_MUL_TRIM;
            end
            S_MUL_TRIM: begin
                o_cmd.mul_trim = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // ramp step jobs; a result superseded by a newer write is dropped
        if (i_stat.div_done) begin
            n_div_busy      = 1'b0;
            o_cmd.ramp_sel  = r_div_sel;
            o_cmd.ramp_load = !r_pend[r_div_sel];
        end
        if (!r_div_busy && r_pend != 2'b00) begin
            o_cmd.div_start = 1'b1;
            o_cmd.div_sel   = r_pend[ssgpm_pkg::SEL_IN] ? ssgpm_pkg::SEL_IN
                                                        : ssgpm_pkg::SEL_OUT;
            n_div_busy      = 1'b1;
            n_div_sel       = o_cmd.div_sel;
            n_pend[o_cmd.div_sel] = 1'b0;
        end
        if (i_stat.in_req) begin
            n_pend[ssgpm_pkg::SEL_IN] = 1'b1;
        end
        if (i_stat.out_req) begin
            n_pend[ssgpm_pkg::SEL_OUT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 2'b00;
            r_div_busy  <= 1'b0;
            r_div_sel   <= ssgpm_pkg::SEL_IN;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_div_busy  <= n_div_busy;
            r_div_sel   <= n_div_sel;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;

endmodule
